// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, held off while reset is high
`define CHK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("checker assertion failed");

// concurrent check that also runs through reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("checker assertion failed");

`endif

// ===== rtl/mflt_pkg.sv =====
// shared constants and types of the median filter
`timescale 1ns / 1ps
package mflt_pkg;

   localparam int WIN       = 7;
   localparam int HALF      = WIN / 2;
   localparam int CELLS     = WIN * WIN;
   localparam int MAX_WIDTH = 1024;
   localparam int PIX_W     = 8;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int FW_W      = 11;
   localparam int FH_W      = 12;
   localparam int POS_R_W   = FH_W + 1;
   localparam int CNT_W     = $clog2(WIN + 1);
   localparam int N_W       = $clog2(CELLS + 1);
   localparam int LB_W      = (WIN - 1) * PIX_W;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 12;

   localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
   localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
   localparam logic [FW_W-1:0] FW_MIN   = FW_W'(3);
   localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
   localparam logic [FH_W-1:0] FH_MIN   = FH_W'(3);

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [CELLS-1:0] win_type;

   typedef struct packed {
      logic valid;
      logic zero;
      logic last;
   } info_type;

   typedef struct packed {
      info_type             info;
      logic [CELLS-1:0]     alive;
      logic [N_W-1:0]       k;
      pix_type              res;
   } rank_type;

endpackage

// ===== rtl/median_filter_7x7_core.sv =====
// 7x7 median filter on a raster-order 8-bit pixel stream
// usage:
//  req_* carries one transaction per item: req_operation selects pixel or drain,
//  req_pixel_value is the grey level of the next raster pixel.
//  rsp_* gives the filtered pixels, one per frame position, in raster order, with
//  rsp_last_of_frame marking the final pixel of the frame.
//  csr_* writes frame_width (index 0) or frame_height (index 1); csr_ready is
//  always high and a write restarts the frame. write only while idle.
//  throughput: one transaction per cycle on both sides while no stall is raised.
//  the selection chain of eight rank cells, one per value bit, starts a new
//  window every cycle while the pipeline is not held. a result passes through
//  the line buffer read, window shift, eight rank cells and output register.
//  results trail the pixel stream by 3 rows plus 3 pixels; drain transactions
//  release the rest once the frame is in. frames of only three rows need three
//  internal fill pushes after the last pixel, during which req_stall is high.
//  reset clears counters and pipeline control; line buffer contents are not
//  cleared by reset.
//  when rsp_stall holds a valid result, the whole pipeline holds and
//  req_stall is raised in the same cycle.
`timescale 1ns / 1ps
module median_filter_7x7_core
   import mflt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [PIX_W-1:0]     req_pixel_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_filtered_value,
   output logic                 rsp_last_of_frame,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   logic [FW_W-1:0]    frame_width_ff;
   logic [FH_W-1:0]    frame_height_ff;
   logic [FW_W-1:0]    w_eff;
   logic [FH_W-1:0]    h_eff;

   logic [POS_R_W-1:0] pr_ff, pr_in;
   logic [COL_W-1:0]   pc_ff, pc_in;
   logic [FH_W-1:0]    or_ff, or_in;
   logic [COL_W-1:0]   oc_ff, oc_in;

   logic               en, acc, done, past_lag, fill, push, emit, last, cfg_wr;
   logic [WIN-1:0]     row_ok, col_ok;
   logic [POS_R_W-1:0] rbase;
   logic [FW_W-1:0]    cbase;
   logic [CNT_W-1:0]   nr, nc;
   logic [N_W-1:0]     n_all;
   rank_type           s0_rank;

   logic               s1_push_ff, s1_valid_ff;
   pix_type            s1_pixel_ff;
   logic [COL_W-1:0]   s1_col_ff;
   rank_type           s1_rank_ff;
   logic               s2_valid_ff;
   rank_type           s2_rank_ff;
   rank_type           s2_rank;
   win_type            window_ff, window_in;
   logic [LB_W-1:0]    lb_rd;
   pix_type            col_vec [WIN];

   win_type            cell_val  [PIX_W+1];
   rank_type           cell_rank [PIX_W+1];

   logic               rsp_valid_ff;
   pix_type            rsp_value_ff;
   logic               rsp_last_ff;

   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FW_RESET;
         frame_height_ff <= FH_RESET;
      end else if (cfg_wr) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FH_W-1:0];
            default:          frame_width_ff  <= frame_width_ff;
         endcase
      end
   end

   assign w_eff = (frame_width_ff < FW_MIN) ? FW_MIN :
                  (frame_width_ff > FW_MAX) ? FW_MAX : frame_width_ff;
   assign h_eff = (frame_height_ff < FH_MIN) ? FH_MIN : frame_height_ff;

   // input side: push position, output position, lag and drain control
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign done      = pr_ff >= {1'b0, h_eff};
   assign past_lag  = (pr_ff > POS_R_W'(HALF)) ||
                      ((pr_ff == POS_R_W'(HALF)) && (pc_ff >= COL_W'(HALF)));
   assign fill      = done && !past_lag;
   assign req_stall = !en || fill;
   assign acc       = req_valid && !req_stall;
   assign push      = (acc && (req_operation == OP_PIXEL) && !done) ||
                      (acc && (req_operation == OP_DRAIN) && done) ||
                      (fill && en);
   assign emit      = push && past_lag;
   assign last      = (or_ff == h_eff - FH_W'(1)) &&
                      ({1'b0, oc_ff} == w_eff - FW_W'(1));

   always_comb begin
      pr_in = pr_ff;
      pc_in = pc_ff;
      or_in = or_ff;
      oc_in = oc_ff;
      if (push) begin
         if (({1'b0, pc_ff} + FW_W'(1)) == w_eff) begin
            pc_in = '0;
            pr_in = pr_ff + POS_R_W'(1);
         end else begin
            pc_in = pc_ff + COL_W'(1);
         end
      end
      if (emit) begin
         if (({1'b0, oc_ff} + FW_W'(1)) == w_eff) begin
            oc_in = '0;
            or_in = or_ff + FH_W'(1);
         end else begin
            oc_in = oc_ff + COL_W'(1);
         end
      end
      if ((emit && last) || cfg_wr) begin
         pr_in = '0;
         pc_in = '0;
         or_in = '0;
         oc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_ff <= '0;
         pc_ff <= '0;
         or_ff <= '0;
         oc_ff <= '0;
      end else begin
         pr_ff <= pr_in;
         pc_ff <= pc_in;
         or_ff <= or_in;
         oc_ff <= oc_in;
      end
   end

   // clipping masks of the window around the output position
   assign rbase = {1'b0, or_ff} + POS_R_W'(HALF);
   assign cbase = {1'b0, oc_ff} + FW_W'(HALF);

   always_comb begin
      for (int i = 0; i < WIN; i++) begin
         row_ok[i] = (rbase >= POS_R_W'(i)) && ((rbase - POS_R_W'(i)) < {1'b0, h_eff});
         col_ok[i] = (cbase >= FW_W'(i)) && ((cbase - FW_W'(i)) < w_eff);
      end
      nr    = CNT_W'($countones(row_ok));
      nc    = CNT_W'($countones(col_ok));
      n_all = N_W'(nr) * N_W'(nc);
      s0_rank            = '0;
      s0_rank.info.valid = emit;
      s0_rank.info.zero  = (or_ff == '0) || (oc_ff == '0) ||
                           (or_ff == h_eff - FH_W'(1)) ||
                           ({1'b0, oc_ff} == w_eff - FW_W'(1));
      s0_rank.info.last  = last;
      s0_rank.k          = n_all >> 1;
      for (int i = 0; i < WIN; i++) begin
         for (int j = 0; j < WIN; j++) begin
            s0_rank.alive[i*WIN+j] = row_ok[i] && col_ok[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_push_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_push_ff  <= push;
         s1_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pixel_ff <= req_pixel_value;
         s1_col_ff   <= pc_ff;
         s1_rank_ff  <= s0_rank;
      end
   end

   mflt_line_buf u_line_buf (
      .clock   (clock),
      .en      (en),
      .rd_addr (pc_ff),
      .rd_data (lb_rd),
      .wr_en   (en && s1_push_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({lb_rd[LB_W-PIX_W-1:0], s1_pixel_ff})
   );

   // column of the newest pixel and the rows above it shifts into the window
   always_comb begin
      col_vec[0] = s1_pixel_ff;
      for (int i = 1; i < WIN; i++) begin
         col_vec[i] = lb_rd[(i-1)*PIX_W +: PIX_W];
      end
      for (int i = 0; i < WIN; i++) begin
         window_in[i*WIN] = col_vec[i];
         for (int j = 1; j < WIN; j++) begin
            window_in[i*WIN+j] = window_ff[i*WIN+j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && s1_push_ff) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_rank_ff <= s1_rank_ff;
      end
   end

   always_comb begin
      s2_rank            = s2_rank_ff;
      s2_rank.info.valid = s2_valid_ff;
   end

   assign cell_val[0]  = window_ff;
   assign cell_rank[0] = s2_rank;

   for (genvar g = 0; g <= PIX_W - 1; g++) begin : g_cell
      mflt_rank_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .val_in   (cell_val[g]),
         .rank_in  (cell_rank[g]),
         .val_out  (cell_val[g+1]),
         .rank_out (cell_rank[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= cell_rank[PIX_W].info.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_value_ff <= cell_rank[PIX_W].info.zero ? '0 : cell_rank[PIX_W].res;
         rsp_last_ff  <= cell_rank[PIX_W].info.last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_last_of_frame  = rsp_last_ff;

endmodule

// ===== rtl/mflt_line_buf.sv =====
// line buffer: one word per column holding the previous rows of that column
`timescale 1ns / 1ps
module mflt_line_buf
   import mflt_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [COL_W-1:0] rd_addr,
   output logic [LB_W-1:0]  rd_data,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [LB_W-1:0]  wr_data
);

   logic [LB_W-1:0] mem [MAX_WIDTH];
   logic [LB_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mflt_rank_cell.sv =====
// rank cell: settles one bit of the selected value, msb first
`timescale 1ns / 1ps
module mflt_rank_cell
   import mflt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  win_type  val_in,
   input  rank_type rank_in,
   output win_type  val_out,
   output rank_type rank_out
);

   logic [CELLS-1:0] msb;
   logic [CELLS-1:0] zeros;
   logic [N_W-1:0]   cnt;
   rank_type         rank_in_nxt;
   win_type          val_nxt;
   rank_type         rank_ff;
   win_type          val_ff;
   logic             valid_ff;

   always_comb begin
      for (int e = 0; e < CELLS; e++) begin
         msb[e]     = val_in[e][PIX_W-1];
         val_nxt[e] = {val_in[e][PIX_W-2:0], 1'b0};
      end
      zeros       = rank_in.alive & ~msb;
      cnt         = N_W'($countones(zeros));
      rank_in_nxt = rank_in;
      // enough candidates with a zero here: the selected value has a zero
      if (rank_in.k < cnt) begin
         rank_in_nxt.alive = zeros;
         rank_in_nxt.res   = {rank_in.res[PIX_W-2:0], 1'b0};
      end else begin
         rank_in_nxt.alive = rank_in.alive & msb;
         rank_in_nxt.k     = rank_in.k - cnt;
         rank_in_nxt.res   = {rank_in.res[PIX_W-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= rank_in.info.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rank_ff <= rank_in_nxt;
         val_ff  <= val_nxt;
      end
   end

   always_comb begin
      rank_out            = rank_ff;
      rank_out.info.valid = valid_ff;
   end

   assign val_out = val_ff;

endmodule

// ===== rtl/mflt_checker.sv =====
// port-level checker for the median filter core, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mflt_checker
   import mflt_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_operation,
   input logic [PIX_W-1:0]     req_pixel_value,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [PIX_W-1:0]     rsp_filtered_value,
   input logic                 rsp_last_of_frame,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CSR_DAT_W-1:0] csr_wdata
);

   // a held result keeps its payload
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered_value) && $stable(rsp_last_of_frame))

   // a stalled result freezes the pipeline, so no new transaction goes in
   `CHK_ASSERT(a_req_blocked, clock, reset, rsp_valid && rsp_stall |-> req_stall)

   // nothing comes out right after reset
   `CHK_ASSERT_ALWAYS(a_rst_quiet, clock, $past(reset) |-> !rsp_valid)

   // the register port never pushes back
   `CHK_ASSERT(a_csr_ready, clock, reset, csr_ready)

endmodule

bind median_filter_7x7_core mflt_checker u_mflt_checker (.*);
